// File: hdl/qspd_pkg.sv
// Shared types, character codes and the hex digit decoder of the query string pair decoder.
`default_nettype none

package qspd_pkg;

  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_AMP     = 8'h26;
  localparam logic [7:0] CH_EQUALS  = 8'h3D;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  typedef enum logic [1:0] {
    KIND_KEY   = 2'd0,
    KIND_VALUE = 2'd1,
    KIND_END   = 2'd2
  } item_kind_e;

  // Pending escape count: nothing held, '%' held, '%' and first digit held.
  typedef enum logic [1:0] {
    PEND_NONE  = 2'd0,
    PEND_PCT   = 2'd1,
    PEND_DIGIT = 2'd2
  } pend_e;

  typedef struct packed {
    logic [7:0] data;
    item_kind_e kind;
    logic       had_eq;
    logic       done;
    logic       last;
  } result_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    h.ok  = 1'b1;
    h.val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.val = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.val = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.val = 4'(c - 8'h37);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

  function automatic result_t mk_result(input logic [7:0] data, input item_kind_e kind,
                                        input logic had_eq, input logic done);
    result_t r;
    r.data   = data;
    r.kind   = kind;
    r.had_eq = had_eq;
    r.done   = done;
    r.last   = 1'b0;
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hdl/query_string_pair_decoder_top.sv
// Top level of the URL query string pair decoder: decode logic and result queue.
`default_nettype none

// The block takes one raw query string byte per transaction, with a flag on the
// final byte, and returns the decoded key bytes, value bytes and end-of-pair
// markers, one result per transaction on the output side. Each accepted byte is
// decoded in the same cycle by a short piece of logic working on the escape
// state, and its results (none to four) are written into a five-entry result
// queue whose head drives the output ports directly. A new byte is accepted
// whenever the queue holds at most one result, so while the output side does
// not stall, bytes that yield zero or one result each are taken back to back:
// the sustained rate is then one byte per cycle. A byte that yields several
// results (a flushed escape plus the byte, or an end-of-pair marker) holds
// the input while the queue drains. The input stall is taken from the queue
// fill register alone, with no path from the output stall. After the final
// byte all decoder state returns to its reset values, ready for the next
// query.
module query_string_pair_decoder_top (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  output logic                  in_stall_o,
  input  wire  [7:0]            raw_byte_i,
  input  wire                   final_byte_i,
  output logic                  out_valid_o,
  input  wire                   out_stall_i,
  output logic [7:0]            decoded_byte_o,
  output logic [1:0]            item_kind_o,
  output logic                  had_equals_o,
  output logic                  query_done_o,
  output logic                  last_of_run_o
);
  import qspd_pkg::*;

  localparam int unsigned QDepth = 5;

  // Decoder state.
  logic       ivp_q, ivp_d;
  pend_e      pc_q, pc_d;
  logic [7:0] pfc_q, pfc_d;

  // Result queue: entry 0 is the head shown on the output ports.
  result_t    q_q [QDepth];
  result_t    q_d [QDepth];
  logic [2:0] cnt_q, cnt_d;

  logic       accept, pop;
  logic [2:0] base;

  // Decode scratch.
  result_t    res [4];
  logic [2:0] n;
  logic       ivp;
  pend_e      pc;
  logic [7:0] pfc;
  hex_t       hx, hp;
  item_kind_e dkind;
  logic [2:0] slot;

  assign in_stall_o  = (cnt_q > 3'd1);
  assign out_valid_o = (cnt_q != 3'd0);
  assign accept      = in_valid_i && !in_stall_o;
  assign pop         = out_valid_o && !out_stall_i;

  assign decoded_byte_o = q_q[0].data;
  assign item_kind_o    = q_q[0].kind;
  assign had_equals_o   = q_q[0].had_eq;
  assign query_done_o   = q_q[0].done;
  assign last_of_run_o  = q_q[0].last;

  // Decode one byte into its ordered results. Each result is appended at
  // index n; at most four can arise (a two-byte flush, the byte, the marker).
  always_comb begin
    res   = '{default: '0};
    n     = 3'd0;
    ivp   = ivp_q;
    pc    = pc_q;
    pfc   = pfc_q;
    hx    = hex_decode(raw_byte_i);
    hp    = hex_decode(pfc_q);
    dkind = ivp_q ? KIND_VALUE : KIND_KEY;

    if (raw_byte_i == CH_AMP) begin
      // Pair ends: flush any cut escape, then the marker.
      if (pc != PEND_NONE) begin
        res[n[1:0]] = mk_result(CH_PERCENT, dkind, 1'b0, 1'b0);
        n = n + 3'd1;
      end
      if (pc == PEND_DIGIT) begin
        res[n[1:0]] = mk_result(pfc, dkind, 1'b0, 1'b0);
        n = n + 3'd1;
      end
      pc  = PEND_NONE;
      pfc = 8'd0;
      res[n[1:0]] = mk_result(8'd0, KIND_END, ivp, final_byte_i);
      n   = n + 3'd1;
      ivp = 1'b0;
    end else if (raw_byte_i == CH_EQUALS && !ivp) begin
      // The splitting equals sign: key part ends.
      if (pc != PEND_NONE) begin
        res[n[1:0]] = mk_result(CH_PERCENT, dkind, 1'b0, 1'b0);
        n = n + 3'd1;
      end
      if (pc == PEND_DIGIT) begin
        res[n[1:0]] = mk_result(pfc, dkind, 1'b0, 1'b0);
        n = n + 3'd1;
      end
      pc  = PEND_NONE;
      pfc = 8'd0;
      ivp = 1'b1;
    end else if (pc == PEND_PCT && hx.ok) begin
      pfc = raw_byte_i;
      pc  = PEND_DIGIT;
    end else if (pc == PEND_DIGIT && hx.ok) begin
      res[n[1:0]] = mk_result({hp.ok ? hp.val : 4'd0, hx.val}, dkind, 1'b0, 1'b0);
      n   = n + 3'd1;
      pc  = PEND_NONE;
      pfc = 8'd0;
    end else begin
      // A bad digit breaks a pending escape, which goes out literally; the
      // byte itself is then handled afresh.
      if (pc != PEND_NONE) begin
        res[n[1:0]] = mk_result(CH_PERCENT, dkind, 1'b0, 1'b0);
        n = n + 3'd1;
      end
      if (pc == PEND_DIGIT) begin
        res[n[1:0]] = mk_result(pfc, dkind, 1'b0, 1'b0);
        n = n + 3'd1;
      end
      pc  = PEND_NONE;
      pfc = 8'd0;
      if (raw_byte_i == CH_PERCENT) begin
        pc = PEND_PCT;
      end else begin
        res[n[1:0]] = mk_result((raw_byte_i == CH_PLUS) ? CH_SPACE : raw_byte_i,
                                dkind, 1'b0, 1'b0);
        n = n + 3'd1;
      end
    end

    if (final_byte_i) begin
      if (raw_byte_i != CH_AMP) begin
        if (pc != PEND_NONE) begin
          res[n[1:0]] = mk_result(CH_PERCENT, dkind, 1'b0, 1'b0);
          n = n + 3'd1;
        end
        if (pc == PEND_DIGIT) begin
          res[n[1:0]] = mk_result(pfc, dkind, 1'b0, 1'b0);
          n = n + 3'd1;
        end
        res[n[1:0]] = mk_result(8'd0, KIND_END, ivp, 1'b1);
        n = n + 3'd1;
      end
      ivp = 1'b0;
      pc  = PEND_NONE;
      pfc = 8'd0;
    end

    if (n != 3'd0) begin
      res[2'(n - 3'd1)].last = 1'b1;
    end

    ivp_d = accept ? ivp : ivp_q;
    pc_d  = accept ? pc  : pc_q;
    pfc_d = accept ? pfc : pfc_q;
  end

  // Queue update: shift out the head when taken, then append the new results
  // behind whatever remains.
  always_comb begin
    base = cnt_q - {2'd0, pop};
    for (int i = 0; i < QDepth; i++) begin
      if (pop && i < QDepth - 1) begin
        q_d[i] = q_q[i + 1];
      end else begin
        q_d[i] = q_q[i];
      end
      slot = 3'(i) - base;
      if (accept && 3'(i) >= base && slot < n) begin
        q_d[i] = res[slot[1:0]];
      end
    end
    cnt_d = base + (accept ? n : 3'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ivp_q <= 1'b0;
      pc_q  <= PEND_NONE;
      pfc_q <= 8'd0;
      cnt_q <= 3'd0;
    end else begin
      ivp_q <= ivp_d;
      pc_q  <= pc_d;
      pfc_q <= pfc_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d;
  end

`ifndef NO_ASSERTIONS
  // The queue never overflows its five entries.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'(QDepth))
    else $error("result queue overflow");

  // After the final byte the decoder state is back at reset values.
  a_final_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && final_byte_i) |=> (!ivp_q && pc_q == PEND_NONE && pfc_q == 8'd0))
    else $error("state not cleared after final byte");

  // End of query is only ever flagged on a marker that closes its run.
  a_done_on_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && query_done_o) |-> (item_kind_o == KIND_END && last_of_run_o))
    else $error("query done outside a closing marker");

  // Markers carry a zero byte; data bytes carry no pair flags.
  a_marker_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((item_kind_o == KIND_END && decoded_byte_o == 8'd0) ||
                     ((item_kind_o == KIND_KEY || item_kind_o == KIND_VALUE) &&
                      !had_equals_o && !query_done_o)))
    else $error("inconsistent result fields");

  // A queued head that is stalled is held.
  a_head_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(decoded_byte_o) &&
                                     $stable(item_kind_o) && $stable(last_of_run_o)))
    else $error("stalled result changed");
`endif

endmodule

`default_nettype wire
